@@ design/mhpq_pkg.sv @@
// shared widths, codes and result type of the max-heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

   localparam int KEY_W        = 32;
   localparam int COUNT_W      = 11;
   localparam int STATUS_W     = 2;
   localparam int CAPACITY_DEF = 1024;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic signed [KEY_W-1:0] popped_key;
      logic [STATUS_W-1:0]     status;
      logic [COUNT_W-1:0]      count;
   } result_type;

endpackage

@@ design/mhpq_ram.sv @@
// heap key store: one write port, two registered read ports
`timescale 1ns / 1ps

module mhpq_ram #(
   parameter int DEPTH = mhpq_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(DEPTH)-1:0]           wr_addr,
   input  logic signed [mhpq_pkg::KEY_W-1:0]  wr_data,
   input  logic [$clog2(DEPTH)-1:0]           rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]           rd_addr_b,
   output logic signed [mhpq_pkg::KEY_W-1:0]  rd_data_a,
   output logic signed [mhpq_pkg::KEY_W-1:0]  rd_data_b
);

   logic signed [mhpq_pkg::KEY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

@@ design/mhpq_ctrl.sv @@
// sift sequencer with the shared key comparator
`timescale 1ns / 1ps

module mhpq_ctrl #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic signed [mhpq_pkg::KEY_W-1:0]   req_key,
   output logic                                mem_we,
   output logic [$clog2(CAPACITY)-1:0]         mem_waddr,
   output logic signed [mhpq_pkg::KEY_W-1:0]   mem_wdata,
   output logic [$clog2(CAPACITY)-1:0]         mem_raddr_a,
   output logic [$clog2(CAPACITY)-1:0]         mem_raddr_b,
   input  logic signed [mhpq_pkg::KEY_W-1:0]   mem_rdata_a,
   input  logic signed [mhpq_pkg::KEY_W-1:0]   mem_rdata_b,
   output logic                                res_valid,
   input  logic                                res_ready,
   output mhpq_pkg::result_type                res
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int IW    = AW + 2;
   localparam int EXT_W = (CW > mhpq_pkg::COUNT_W) ? CW : mhpq_pkg::COUNT_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UP     = 3'd1;
   localparam logic [2:0] S_UP_CMP = 3'd2;
   localparam logic [2:0] S_POP_LD = 3'd3;
   localparam logic [2:0] S_DN     = 3'd4;
   localparam logic [2:0] S_DN_SEL = 3'd5;
   localparam logic [2:0] S_DN_CMP = 3'd6;
   localparam logic [2:0] S_FIN    = 3'd7;

   logic [2:0]                        state_ff, state_in;
   logic [AW-1:0]                     pos_ff, pos_in;
   logic [AW-1:0]                     big_ff, big_in;
   logic signed [mhpq_pkg::KEY_W-1:0] key_ff, key_in;
   logic signed [mhpq_pkg::KEY_W-1:0] bval_ff, bval_in;
   logic signed [mhpq_pkg::KEY_W-1:0] popped_ff, popped_in;
   logic [mhpq_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic                              rvalid_ff, rvalid_in;

   logic signed [mhpq_pkg::KEY_W-1:0] cmp_a, cmp_b;
   logic                              lt;
   logic [AW-1:0]                     parent;
   logic [IW-1:0]                     left_ix, right_ix, n_ext;
   logic [EXT_W-1:0]                  count_ext;

   // the one comparator, operands steered by the sequencer
   assign lt = cmp_a < cmp_b;

   assign parent   = (pos_ff - AW'(1)) >> 1;
   assign left_ix  = {1'b0, pos_ff, 1'b1};
   assign right_ix = left_ix + IW'(1);
   assign n_ext    = IW'(count_ff);

   assign count_ext      = EXT_W'(count_ff);
   assign res.popped_key = popped_ff;
   assign res.status     = status_ff;
   assign res.count      = count_ext[mhpq_pkg::COUNT_W-1:0];

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_FIN);

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      big_in      = big_ff;
      key_in      = key_ff;
      bval_in     = bval_ff;
      popped_in   = popped_ff;
      status_in   = status_ff;
      count_in    = count_ff;
      rvalid_in   = rvalid_ff;
      mem_we      = 1'b0;
      mem_waddr   = pos_ff;
      mem_wdata   = key_ff;
      mem_raddr_a = parent;
      mem_raddr_b = left_ix[AW-1:0];
      cmp_a       = key_ff;
      cmp_b       = bval_ff;
      unique case (state_ff)
         S_IDLE: begin
            // root and last leaf are fetched up front for a pop
            mem_raddr_a = '0;
            mem_raddr_b = AW'(count_ff - CW'(1));
            if (req_valid) begin
               popped_in = '0;
               status_in = mhpq_pkg::ST_DONE;
               key_in    = req_key;
               if (req_command == mhpq_pkg::CMD_INSERT) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     status_in = mhpq_pkg::ST_FULL;
                     state_in  = S_FIN;
                  end else begin
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     state_in = S_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = mhpq_pkg::ST_EMPTY;
                     state_in  = S_FIN;
                  end else begin
                     pos_in   = '0;
                     count_in = count_ff - CW'(1);
                     state_in = S_POP_LD;
                  end
               end
            end
         end
         S_POP_LD: begin
            popped_in = mem_rdata_a;
            key_in    = mem_rdata_b;
            state_in  = S_DN;
         end
         S_UP: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            cmp_a = mem_rdata_a;
            cmp_b = key_ff;
            mem_we = 1'b1;
            if (lt) begin
               // parent moves down into the hole
               mem_wdata = mem_rdata_a;
               pos_in    = parent;
               state_in  = S_UP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DN: begin
            mem_raddr_a = left_ix[AW-1:0];
            mem_raddr_b = right_ix[AW-1:0];
            if (left_ix >= n_ext) begin
               mem_we   = 1'b1;
               state_in = S_FIN;
            end else begin
               rvalid_in = (right_ix < n_ext);
               state_in  = S_DN_SEL;
            end
         end
         S_DN_SEL: begin
            cmp_a = mem_rdata_a;
            cmp_b = mem_rdata_b;
            // left child wins ties
            if (rvalid_ff && lt) begin
               big_in  = right_ix[AW-1:0];
               bval_in = mem_rdata_b;
            end else begin
               big_in  = left_ix[AW-1:0];
               bval_in = mem_rdata_a;
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            mem_we = 1'b1;
            if (lt) begin
               mem_wdata = bval_ff;
               pos_in    = big_ff;
               state_in  = S_DN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      big_ff    <= big_in;
      key_ff    <= key_in;
      bval_ff   <= bval_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      rvalid_ff <= rvalid_in;
   end

endmodule

@@ design/max_heap_priority_queue.sv @@
// Binary max-heap priority queue of signed 32-bit keys.
// The req channel carries one operation per item: command 0 inserts
// req_key, command 1 pops the largest key. Each item yields exactly one
// rsp item with the popped key (zero unless a pop succeeded), a status
// (done, pop on empty, insert on full) and the key count afterwards.
// Keys sit in an on-chip store of CAPACITY entries; a sequencer walks the
// tree with one shared signed comparator, one store write port and two
// registered read ports.
// An insert lets the key rise level by level past smaller parents; a pop
// moves the last leaf to the root and lets it sink below its larger child.
// One item is in work at a time; req_ready is high only when the
// sequencer is idle, which it reenters once its result is handed on, so no
// item is taken before the last is through. The finished item sits in an
// output register, so the next req item is taken while rsp waits; a
// stalled receiver holds the sequencer only once a second result is ready.
// Reset empties the queue (count zero, no result pending); store
// contents need no clearing since only held entries are ever used.
`timescale 1ns / 1ps

module max_heap_priority_queue #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic                                       req_command,
   input  logic signed [mhpq_pkg::KEY_W-1:0]          req_key,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [mhpq_pkg::KEY_W-1:0]          rsp_popped_key,
   output logic [mhpq_pkg::STATUS_W-1:0]              rsp_status,
   output logic [mhpq_pkg::COUNT_W-1:0]               rsp_count
);

   localparam int AW = $clog2(CAPACITY);

   logic                              mem_we;
   logic [AW-1:0]                     mem_waddr;
   logic signed [mhpq_pkg::KEY_W-1:0] mem_wdata;
   logic [AW-1:0]                     mem_raddr_a, mem_raddr_b;
   logic signed [mhpq_pkg::KEY_W-1:0] mem_rdata_a, mem_rdata_b;

   logic                 res_valid, res_ready;
   mhpq_pkg::result_type res;

   logic                 out_valid_ff, out_valid_in;
   mhpq_pkg::result_type out_ff, out_in;

   mhpq_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (mem_raddr_a),
      .rd_addr_b (mem_raddr_b),
      .rd_data_a (mem_rdata_a),
      .rd_data_b (mem_rdata_b)
   );

   mhpq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_key     (req_key),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_raddr_a (mem_raddr_a),
      .mem_raddr_b (mem_raddr_b),
      .mem_rdata_a (mem_rdata_a),
      .mem_rdata_b (mem_rdata_b),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   // output slot frees up in the same cycle it is taken
   assign res_ready = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_popped_key = out_ff.popped_key;
   assign rsp_status     = out_ff.status;
   assign rsp_count      = out_ff.count;

`ifndef SYNTHESIS
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer took a second item while busy");

   a_empty_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::ST_EMPTY |->
         rsp_count == '0 && rsp_popped_key == '0)
      else $error("empty pop reported a key or a nonzero count");

   a_full_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::ST_FULL |->
         rsp_count == mhpq_pkg::COUNT_W'(CAPACITY) && rsp_popped_key == '0)
      else $error("full insert reported with wrong count or key");
`endif

endmodule
